FILE: hdl/glce_pkg.sv
`timescale 1ns / 1ps

package glce_pkg;

    localparam int SYM_BITS      = 8;
    localparam int CODE_BITS     = 12;
    localparam int FREE_BITS     = CODE_BITS + 1;
    localparam int WIDTH_BITS    = 4;
    localparam int ADDR_BITS     = CODE_BITS + SYM_BITS;
    localparam int DICT_DEPTH    = 1 << ADDR_BITS;
    localparam int EPOCH_BITS    = 8;
    localparam int BYTE_BITS     = 8;

    localparam int CODE_LIMIT    = 1 << CODE_BITS;
    localparam int CLEAR_CODE    = 1 << SYM_BITS;
    localparam int END_CODE      = CLEAR_CODE + 1;
    localparam int FIRST_FREE    = CLEAR_CODE + 2;
    localparam int INIT_WIDTH    = SYM_BITS + 1;

    // up to four codes leave the dictionary stage for one item
    localparam int PUSH_MAX      = 4;
    localparam int PUSH_IDX_BITS = 2;
    localparam int PUSH_CNT_BITS = 3;

    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_BITS = 3;
    localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

    // bit buffer holds at most seven leftover bits plus one code
    localparam int PACK_BITS     = BYTE_BITS - 1 + CODE_BITS;
    localparam int PACK_CNT_BITS = 5;

    typedef struct packed {
        logic [7:0] pixel_index;
        logic       last_pixel;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       image_end;
    } t_out_item;

    typedef struct packed {
        logic                  last_code;
        logic [WIDTH_BITS-1:0] width;
        logic [CODE_BITS-1:0]  code;
    } t_code_item;

    typedef struct packed {
        logic [PUSH_CNT_BITS-1:0]          count;
        t_code_item [PUSH_MAX-1:0]         item;
    } t_push;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] epoch;
        logic [CODE_BITS-1:0]  code;
    } t_dict_word;

endpackage

FILE: hdl/glce_packer.sv
`timescale 1ns / 1ps

module glce_packer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  glce_pkg::t_push    i_push,
    output logic               o_room,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output glce_pkg::t_out_item o_out
);

    glce_pkg::t_code_item r_fifo [glce_pkg::FIFO_DEPTH];

    logic [glce_pkg::FIFO_PTR_BITS-1:0] r_wptr, n_wptr;
    logic [glce_pkg::FIFO_PTR_BITS-1:0] r_rptr, n_rptr;
    logic [glce_pkg::FIFO_CNT_BITS-1:0] r_count, n_count;
    logic [glce_pkg::PACK_BITS-1:0]     r_pbits, n_pbits;
    logic [glce_pkg::PACK_CNT_BITS-1:0] r_pcnt, n_pcnt;
    logic                               r_flush, n_flush;
    logic                               r_ovalid, n_ovalid;
    glce_pkg::t_out_item                r_out, n_out;

    glce_pkg::t_code_item               head;
    logic [glce_pkg::CODE_BITS-1:0]     code_mask;
    logic [glce_pkg::PACK_BITS-1:0]     base_bits;
    logic [glce_pkg::PACK_CNT_BITS-1:0] base_cnt;
    logic                               out_free;
    logic                               emit_full;
    logic                               emit_part;
    logic                               end_byte;
    logic                               pop;

    assign o_room      = r_count <= glce_pkg::FIFO_CNT_BITS'(glce_pkg::FIFO_DEPTH
                                                            - glce_pkg::PUSH_MAX);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    assign head      = r_fifo[r_rptr];
    assign code_mask = glce_pkg::CODE_BITS'(
                           (glce_pkg::FREE_BITS'(1) << head.width) - glce_pkg::FREE_BITS'(1));

    always_comb begin
        out_free  = !r_ovalid || i_out_ready;
        emit_full = (r_pcnt >= glce_pkg::PACK_CNT_BITS'(glce_pkg::BYTE_BITS)) && out_free;
        // end of image: the leftover bits go out as a partial byte
        emit_part = r_flush && (r_pcnt < glce_pkg::PACK_CNT_BITS'(glce_pkg::BYTE_BITS))
                    && (r_pcnt != '0) && out_free;
        end_byte  = r_flush && (emit_part || (emit_full &&
                    r_pcnt == glce_pkg::PACK_CNT_BITS'(glce_pkg::BYTE_BITS)));

        if (emit_full) begin
            base_bits = r_pbits >> glce_pkg::BYTE_BITS;
            base_cnt  = r_pcnt - glce_pkg::PACK_CNT_BITS'(glce_pkg::BYTE_BITS);
        end else begin
            base_bits = r_pbits;
            base_cnt  = r_pcnt;
        end

        pop = !r_flush && (base_cnt < glce_pkg::PACK_CNT_BITS'(glce_pkg::BYTE_BITS))
              && (r_count != '0);

        if (emit_part) begin
            n_pbits = '0;
            n_pcnt  = '0;
        end else if (pop) begin
            n_pbits = base_bits | (glce_pkg::PACK_BITS'(head.code & code_mask) << base_cnt);
            n_pcnt  = base_cnt + glce_pkg::PACK_CNT_BITS'(head.width);
        end else begin
            n_pbits = base_bits;
            n_pcnt  = base_cnt;
        end

        if (pop) begin
            n_flush = head.last_code;
        end else if (end_byte) begin
            n_flush = 1'b0;
        end else begin
            n_flush = r_flush;
        end

        n_rptr  = pop ? r_rptr + glce_pkg::FIFO_PTR_BITS'(1) : r_rptr;
        n_wptr  = r_wptr + glce_pkg::FIFO_PTR_BITS'(i_push.count);
        n_count = r_count + glce_pkg::FIFO_CNT_BITS'(i_push.count)
                  - glce_pkg::FIFO_CNT_BITS'(pop);

        n_out = r_out;
        if (emit_full || emit_part) begin
            n_ovalid        = 1'b1;
            n_out.out_byte  = r_pbits[glce_pkg::BYTE_BITS-1:0];
            n_out.image_end = end_byte;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < glce_pkg::PUSH_MAX; k++) begin
            if (glce_pkg::PUSH_CNT_BITS'(k) < i_push.count) begin
                r_fifo[r_wptr + glce_pkg::FIFO_PTR_BITS'(k)] <= i_push.item[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_count  <= '0;
            r_pbits  <= '0;
            r_pcnt   <= '0;
            r_flush  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_wptr   <= n_wptr;
            r_rptr   <= n_rptr;
            r_count  <= n_count;
            r_pbits  <= n_pbits;
            r_pcnt   <= n_pcnt;
            r_flush  <= n_flush;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

FILE: hdl/gif_lzw_code_stream_encoder.sv
`timescale 1ns / 1ps
// channel   valid / ready               payload                       direction
// -------   -------------------------   ---------------------------   ---------
// pixel     i_in_valid / o_in_ready     i_in  (pixel_index, last_pixel)   in
// byte      o_out_valid / i_out_ready   o_out (out_byte, image_end)       out
//
// The dictionary memory is read in the cycle a pixel is accepted and written
// back in the next one, and the next lookup needs the prefix that this
// write-back decides. Bytes leave at up to one per cycle unless the output stalls.
// After reset, and after every 255th dictionary clear, a sweep marks all 2^20
// dictionary entries empty; no pixel is accepted during it.
// A stalled byte output holds pixels back once the internal code queue fills.

module gif_lzw_code_stream_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  glce_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output glce_pkg::t_out_item o_out
);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_LOOK,
        ST_DEC
    } t_state;

    glce_pkg::t_dict_word r_dict [glce_pkg::DICT_DEPTH];
    glce_pkg::t_dict_word r_rdata;

    t_state                              r_state, n_state;
    logic [glce_pkg::ADDR_BITS-1:0]      r_sweep_addr, n_sweep_addr;
    logic [glce_pkg::EPOCH_BITS-1:0]     r_epoch, n_epoch;
    logic [glce_pkg::CODE_BITS-1:0]      r_prefix, n_prefix;
    logic [glce_pkg::FREE_BITS-1:0]      r_free, n_free;
    logic [glce_pkg::WIDTH_BITS-1:0]     r_width, n_width;
    logic                                r_in_image, n_in_image;
    logic [glce_pkg::SYM_BITS-1:0]       r_sym, n_sym;
    logic                                r_last, n_last;

    logic [glce_pkg::SYM_BITS-1:0]       sym;
    logic [glce_pkg::ADDR_BITS-1:0]      rd_addr;
    logic                                room;
    logic                                accept;
    logic                                mem_we;
    logic [glce_pkg::ADDR_BITS-1:0]      mem_waddr;
    glce_pkg::t_dict_word                mem_wdata;
    glce_pkg::t_push                     push;
    logic [glce_pkg::PUSH_CNT_BITS-1:0]  k;
    logic                                clr;

    assign sym        = i_in.pixel_index[glce_pkg::SYM_BITS-1:0];
    assign rd_addr    = {r_prefix, sym};
    assign o_in_ready = (r_state == ST_LOOK) && room;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        n_epoch      = r_epoch;
        n_prefix     = r_prefix;
        n_free       = r_free;
        n_width      = r_width;
        n_in_image   = r_in_image;
        n_sym        = r_sym;
        n_last       = r_last;
        mem_we       = 1'b0;
        mem_waddr    = {r_prefix, r_sym};
        mem_wdata    = '{epoch: r_epoch, code: r_free[glce_pkg::CODE_BITS-1:0]};
        push         = '0;
        k            = '0;
        clr          = 1'b0;

        case (r_state)
            ST_SWEEP: begin
                // epoch zero marks an entry as never written
                mem_we       = 1'b1;
                mem_waddr    = r_sweep_addr;
                mem_wdata    = '0;
                n_sweep_addr = r_sweep_addr + glce_pkg::ADDR_BITS'(1);
                if (r_sweep_addr == '1) begin
                    n_state = ST_LOOK;
                    n_epoch = glce_pkg::EPOCH_BITS'(1);
                end
            end
            ST_LOOK: begin
                if (accept) begin
                    n_sym   = sym;
                    n_last  = i_in.last_pixel;
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                n_state = ST_LOOK;
                if (!r_in_image) begin
                    push.item[k[glce_pkg::PUSH_IDX_BITS-1:0]] =
                        '{last_code: 1'b0, width: r_width,
                          code: glce_pkg::CODE_BITS'(glce_pkg::CLEAR_CODE)};
                    k          = k + glce_pkg::PUSH_CNT_BITS'(1);
                    n_prefix   = glce_pkg::CODE_BITS'(r_sym);
                    n_in_image = 1'b1;
                end else if (r_rdata.epoch == r_epoch) begin
                    n_prefix = r_rdata.code;
                end else begin
                    push.item[k[glce_pkg::PUSH_IDX_BITS-1:0]] =
                        '{last_code: 1'b0, width: r_width, code: r_prefix};
                    k = k + glce_pkg::PUSH_CNT_BITS'(1);
                    if (r_free < glce_pkg::FREE_BITS'(glce_pkg::CODE_LIMIT)) begin
                        mem_we = 1'b1;
                        // width grows when the added code is a power of two
                        if (r_free == (glce_pkg::FREE_BITS'(1) << r_width) &&
                            r_width < glce_pkg::WIDTH_BITS'(glce_pkg::CODE_BITS)) begin
                            n_width = r_width + glce_pkg::WIDTH_BITS'(1);
                        end
                        n_free = r_free + glce_pkg::FREE_BITS'(1);
                    end else begin
                        push.item[k[glce_pkg::PUSH_IDX_BITS-1:0]] =
                            '{last_code: 1'b0, width: r_width,
                              code: glce_pkg::CODE_BITS'(glce_pkg::CLEAR_CODE)};
                        k       = k + glce_pkg::PUSH_CNT_BITS'(1);
                        clr     = 1'b1;
                        n_width = glce_pkg::WIDTH_BITS'(glce_pkg::INIT_WIDTH);
                        n_free  = glce_pkg::FREE_BITS'(glce_pkg::FIRST_FREE);
                    end
                    n_prefix = glce_pkg::CODE_BITS'(r_sym);
                end

                if (r_last) begin
                    push.item[k[glce_pkg::PUSH_IDX_BITS-1:0]] =
                        '{last_code: 1'b0, width: n_width, code: n_prefix};
                    k = k + glce_pkg::PUSH_CNT_BITS'(1);
                    push.item[k[glce_pkg::PUSH_IDX_BITS-1:0]] =
                        '{last_code: 1'b1, width: n_width,
                          code: glce_pkg::CODE_BITS'(glce_pkg::END_CODE)};
                    k          = k + glce_pkg::PUSH_CNT_BITS'(1);
                    clr        = 1'b1;
                    n_prefix   = '0;
                    n_width    = glce_pkg::WIDTH_BITS'(glce_pkg::INIT_WIDTH);
                    n_free     = glce_pkg::FREE_BITS'(glce_pkg::FIRST_FREE);
                    n_in_image = 1'b0;
                end

                // emptying the dictionary moves to a fresh epoch, or to a sweep once the epochs run out
                if (clr) begin
                    if (r_epoch == '1) begin
                        n_state = ST_SWEEP;
                    end else begin
                        n_epoch = r_epoch + glce_pkg::EPOCH_BITS'(1);
                    end
                end
                push.count = k;
            end
            default: begin
                n_state = ST_SWEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_dict[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_dict[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_sym  <= n_sym;
        r_last <= n_last;
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_epoch      <= glce_pkg::EPOCH_BITS'(1);
            r_prefix     <= '0;
            r_free       <= glce_pkg::FREE_BITS'(glce_pkg::FIRST_FREE);
            r_width      <= glce_pkg::WIDTH_BITS'(glce_pkg::INIT_WIDTH);
            r_in_image   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            r_epoch      <= n_epoch;
            r_prefix     <= n_prefix;
            r_free       <= n_free;
            r_width      <= n_width;
            r_in_image   <= n_in_image;
        end
    end

    glce_packer u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
